### sv/rotary_encoder_step_and_button_assert.svh
// ---------------------------------------------------------------------------
// Rotary encoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_STEP_AND_BUTTON_ASSERT_SVH
`define ROTARY_ENCODER_STEP_AND_BUTTON_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ROTENC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ROTENC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/rotenc_pkg.sv
// ---------------------------------------------------------------------------
// Rotary encoder package
// Widths, reset values, register indexes and shared types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rotenc_pkg;

	localparam int TIMER_W     = 16;
	localparam int TIME_W      = 32;
	localparam int STEPS_W     = 16;
	localparam int MAX_DELTA_W = 7;
	localparam int DEBOUNCE_W  = 8;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	localparam int COUNTS_PER_STEP_DEF = 2;

	localparam logic [MAX_DELTA_W-1:0] MAX_DELTA_RST = 7'd8;
	localparam logic [DEBOUNCE_W-1:0]  DEBOUNCE_RST  = 8'd10;

	localparam logic [STEPS_W-1:0] STEPS_MAX = 16'h7FFF;
	localparam logic [STEPS_W-1:0] STEPS_MIN = 16'h8000;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 1'd1;

	typedef struct packed {
		logic fire;
		logic first;
		logic take;
	} poll_ctl_t;

endpackage

### sv/rotenc_step.sv
// ---------------------------------------------------------------------------
// Rotary encoder step accumulator
// Wrapped counter delta, glitch filter, detent division and saturating total.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotenc_step
	import rotenc_pkg::*;
#(
	parameter int COUNTS_PER_STEP = COUNTS_PER_STEP_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  poll_ctl_t              ctl,
	input  logic [TIMER_W-1:0]     timer_count,
	input  logic [MAX_DELTA_W-1:0] max_delta,
	output logic [STEPS_W-1:0]     move_steps
);

	localparam int REM_W   = $clog2(COUNTS_PER_STEP) + 1;
	localparam int SUM_W   = 9;
	localparam int MAG_W   = 8;
	localparam int RECIP_W = 17;
	localparam int PROD_W  = MAG_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((65536 + COUNTS_PER_STEP - 1) / COUNTS_PER_STEP);
	localparam logic [MAG_W-1:0] CPS = MAG_W'(COUNTS_PER_STEP);

	logic [TIMER_W-1:0]      prev_count_q;
	logic signed [REM_W-1:0] rem_q;
	logic [STEPS_W-1:0]      steps_q;

	logic [TIMER_W-1:0]      diff;
	logic signed [16:0]      diff_ext;
	logic signed [16:0]      limit;
	logic                    in_range;
	logic [7:0]              delta;
	logic [SUM_W-1:0]        sum;
	logic [SUM_W-1:0]        sum_abs;
	logic [MAG_W-1:0]        mag;
	logic [PROD_W-1:0]       prod;
	logic [MAG_W-1:0]        q_mag;
	logic [MAG_W-1:0]        r_mag;
	logic [SUM_W-1:0]        quot;
	logic [REM_W-1:0]        rem_nxt;
	logic [STEPS_W:0]        total;
	logic [STEPS_W-1:0]      total_sat;

	always_comb begin
		diff     = timer_count - prev_count_q;
		diff_ext = $signed({diff[TIMER_W-1], diff});
		limit    = $signed({10'd0, max_delta});
		in_range = (diff_ext <= limit) && (diff_ext >= -limit);
		delta    = in_range ? diff[7:0] : 8'd0;
		sum      = {delta[7], delta} +
			{{(SUM_W-REM_W){rem_q[REM_W-1]}}, rem_q};
		sum_abs  = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
		mag      = sum_abs[MAG_W-1:0];
		prod     = PROD_W'(mag) * PROD_W'(RECIP);
		q_mag    = prod[PROD_W-2:16];
		r_mag    = mag - (q_mag * CPS);
		quot     = sum[SUM_W-1] ? (~{1'b0, q_mag} + 1'b1) : {1'b0, q_mag};
		rem_nxt  = sum[SUM_W-1] ? REM_W'(~r_mag + 1'b1) : REM_W'(r_mag);
		total    = {steps_q[STEPS_W-1], steps_q} +
			{{(STEPS_W+1-SUM_W){quot[SUM_W-1]}}, quot};
		if (total[STEPS_W] != total[STEPS_W-1]) begin
			total_sat = total[STEPS_W] ? STEPS_MIN : STEPS_MAX;
		end else begin
			total_sat = total[STEPS_W-1:0];
		end
		move_steps = ctl.first ? '0 : total_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_count_q <= '0;
			rem_q        <= '0;
			steps_q      <= '0;
		end else if (ctl.fire) begin
			prev_count_q <= timer_count;
			if (ctl.first) begin
				rem_q   <= '0;
				steps_q <= '0;
			end else begin
				rem_q   <= $signed(rem_nxt);
				steps_q <= ctl.take ? '0 : total_sat;
			end
		end
	end

endmodule

### sv/rotenc_button.sv
// ---------------------------------------------------------------------------
// Rotary encoder button debounce
// Time based debounce of the raw level with a latched click on each press.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotenc_button
	import rotenc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  poll_ctl_t             ctl,
	input  logic                  button_level,
	input  logic [TIME_W-1:0]     time_ms,
	input  logic [DEBOUNCE_W-1:0] debounce_ms,
	output logic                  click,
	output logic                  pressed
);

	logic              prev_level_q;
	logic              stable_q;
	logic              idle_q;
	logic              click_q;
	logic [TIME_W-1:0] change_time_q;

	logic              changed;
	logic [TIME_W-1:0] change_time_nxt;
	logic [TIME_W-1:0] elapsed;
	logic              settled;
	logic              stable_nxt;
	logic              click_nxt;

	always_comb begin
		changed         = button_level != prev_level_q;
		change_time_nxt = changed ? time_ms : change_time_q;
		elapsed         = time_ms - change_time_nxt;
		settled         = elapsed >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ms};
		stable_nxt      = settled ? button_level : stable_q;
		click_nxt       = click_q |
			(settled && (stable_q != button_level) && (stable_q == idle_q));
		click           = ctl.first ? 1'b0 : click_nxt;
		pressed         = ctl.first ? 1'b0 : (stable_nxt != idle_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q  <= 1'b0;
			stable_q      <= 1'b0;
			idle_q        <= 1'b0;
			click_q       <= 1'b0;
			change_time_q <= '0;
		end else if (ctl.fire) begin
			if (ctl.first) begin
				prev_level_q  <= button_level;
				stable_q      <= button_level;
				idle_q        <= button_level;
				click_q       <= 1'b0;
				change_time_q <= time_ms;
			end else begin
				prev_level_q  <= button_level;
				stable_q      <= stable_nxt;
				click_q       <= ctl.take ? 1'b0 : click_nxt;
				change_time_q <= change_time_nxt;
			end
		end
	end

endmodule

### sv/rotary_encoder_step_and_button.sv
// Throughput: one request per cycle while the result register is not stalled by a low
// m_axis_tready; input register, one pass of logic, result register.
// A request is accepted whenever the result register is empty or being taken.
// Reset clears the valid flags and encoder state; max_delta resets to 8 and debounce_ms to 10.
// The first request after reset sets the counter baseline and idle level.
// ---------------------------------------------------------------------------
// Rotary encoder step and button top level
// Streaming poll interface, configuration registers and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotary_encoder_step_and_button
	import rotenc_pkg::*;
#(
	parameter int COUNTS_PER_STEP = COUNTS_PER_STEP_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// timer_count[15:0], button_level[16], time_ms[48:17], take_steps[49], take_click[50]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// move_steps[15:0], click[16], pressed[17]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [MAX_DELTA_W-1:0] max_delta_q;
	logic [DEBOUNCE_W-1:0]  debounce_ms_q;
	logic                   started_q;

	logic                   valid_s1;
	logic [TIMER_W-1:0]     count_s1;
	logic                   level_s1;
	logic [TIME_W-1:0]      time_s1;
	logic                   take_steps_s1;
	logic                   take_click_s1;

	logic                   valid_s2;
	logic [STEPS_W-1:0]     steps_s2;
	logic                   click_s2;
	logic                   pressed_s2;

	logic                   advance;
	poll_ctl_t              step_ctl;
	poll_ctl_t              button_ctl;
	logic [STEPS_W-1:0]     move_steps;
	logic                   click;
	logic                   pressed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_delta_q   <= MAX_DELTA_RST;
			debounce_ms_q <= DEBOUNCE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MAX_DELTA:   max_delta_q   <= cfg_data[MAX_DELTA_W-1:0];
				REG_DEBOUNCE_MS: debounce_ms_q <= cfg_data[DEBOUNCE_W-1:0];
			endcase
		end
	end

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			count_s1      <= s_axis_tdata[15:0];
			level_s1      <= s_axis_tdata[16];
			time_s1       <= s_axis_tdata[48:17];
			take_steps_s1 <= s_axis_tdata[49];
			take_click_s1 <= s_axis_tdata[50];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
		end else if (advance) begin
			started_q <= 1'b1;
		end
	end

	always_comb begin
		step_ctl.fire    = advance;
		step_ctl.first   = !started_q;
		step_ctl.take    = take_steps_s1;
		button_ctl.fire  = advance;
		button_ctl.first = !started_q;
		button_ctl.take  = take_click_s1;
	end

	rotenc_step #(
		.COUNTS_PER_STEP(COUNTS_PER_STEP)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (step_ctl),
		.timer_count(count_s1),
		.max_delta  (max_delta_q),
		.move_steps (move_steps)
	);

	rotenc_button u_button (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (button_ctl),
		.button_level(level_s1),
		.time_ms     (time_s1),
		.debounce_ms (debounce_ms_q),
		.click       (click),
		.pressed     (pressed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			steps_s2   <= move_steps;
			click_s2   <= click;
			pressed_s2 <= pressed;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'd0, pressed_s2, click_s2, steps_s2};

endmodule

### sv/rotenc_checker.sv
// ---------------------------------------------------------------------------
// Rotary encoder port checker
// Watches the stream ports of the top level for pipeline slips.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rotary_encoder_step_and_button_assert.svh"

module rotenc_checker
	import rotenc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	`ROTENC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

	`ROTENC_ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "request refused while result register is empty")

	`ROTENC_ASSERT_SAME(a_result_has_request, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "result without a request two cycles earlier")

endmodule

bind rotary_encoder_step_and_button rotenc_checker u_rotenc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
